### rtl/csh_pkg.sv
// Shared constants and types for the cross-kernel sharpen block.
`default_nettype none
package csh_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CHANNELS   = 3;
  localparam int MIN_DIM    = 3;
  localparam int CHAN_W     = 8;
  localparam int DIM_W      = 13;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFG_IDX_W  = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_DRAIN = 1'b1
  } req_t;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] pix_t;

  typedef struct packed {
    logic              req_type;
    logic [CHAN_W-1:0] in_blue;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_red;
  } in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic              frame_end;
  } out_t;

  // write/read controls of one line store
  typedef struct packed {
    logic             we;
    logic [COL_W-1:0] waddr;
    logic             re;
    logic [COL_W-1:0] raddr;
  } ram_ctl_t;

endpackage
`default_nettype wire

### rtl/csh_line_ram.sv
// One row of pixels: one write port, one registered read port.
`default_nettype none
module csh_line_ram (
  input  wire logic            clk,
  input  wire csh_pkg::ram_ctl_t ctl,
  input  wire csh_pkg::pix_t   wdata,
  output csh_pkg::pix_t        rdata_r
);

  csh_pkg::pix_t mem [csh_pkg::MAX_WIDTH];

  // read returns the old entry when the same address is written
  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rdata_r <= mem[ctl.raddr];
    end
    if (ctl.we) begin
      mem[ctl.waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

### rtl/csh_lane.sv
// One channel of the cross kernel: 5*c - l - r - u - d, clamped to 0..255.
`default_nettype none
module csh_lane (
  input  wire logic [csh_pkg::CHAN_W-1:0] c,
  input  wire logic [csh_pkg::CHAN_W-1:0] l,
  input  wire logic [csh_pkg::CHAN_W-1:0] r,
  input  wire logic [csh_pkg::CHAN_W-1:0] u,
  input  wire logic [csh_pkg::CHAN_W-1:0] d,
  output logic      [csh_pkg::CHAN_W-1:0] y
);

  localparam int SUM_W = csh_pkg::CHAN_W + 4;

  logic        [SUM_W-1:0] five_c;
  logic        [SUM_W-1:0] ring;
  logic signed [SUM_W-1:0] v;

  always_comb begin
    five_c = (SUM_W'(c) << 2) + SUM_W'(c);
    ring   = SUM_W'(l) + SUM_W'(r) + SUM_W'(u) + SUM_W'(d);
    v      = $signed(five_c - ring);
    if (v < 0) begin
      y = '0;
    end else if (v > $signed(SUM_W'((1 << csh_pkg::CHAN_W) - 1))) begin
      y = '1;
    end else begin
      y = v[csh_pkg::CHAN_W-1:0];
    end
  end

endmodule
`default_nettype wire

### rtl/cross_kernel_sharpen.sv
// Top level of the 3x3 cross-kernel sharpen filter for raster pixel streams.
//
// Takes one transaction per clock while no stalled result backs up the input:
// a pixel (req_type 0) or a drain tick (req_type 1). Each channel of an
// interior pixel becomes 5*center - left - right - up - down, clamped to
// 0..255; first/last rows and columns give zero. Results lag input by one
// row plus one pixel, so after the last pixel of a frame W+1 drain ticks
// flush the tail; frame_end marks the result of the bottom-right pixel. An
// accepted transaction passes the second stage into the output register,
// where its result is held while out_stall is high; the sustained rate is
// one transaction per clock without stalls, set by the single read port of
// each line store (one read at the current column per pixel). Line stores
// need no clearing pass: their first-row reads only feed border results.
// frame_width / frame_height are saturated to 3..4096 and must only be written
// while no transaction is in flight.
`default_nettype none
module cross_kernel_sharpen (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [csh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [csh_pkg::DIM_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire csh_pkg::in_t                   in_data,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output csh_pkg::out_t                       out_data
);

  localparam int DW = csh_pkg::DIM_W;
  localparam int CW = csh_pkg::COL_W;
  localparam int RW = csh_pkg::ROW_W;

  // configuration
  logic [DW-1:0] width_r, height_r;
  logic [DW-1:0] w_eff, h_eff, wm1, hm1;

  // input side position and output position used by drain ticks
  logic [CW-1:0] col_r, col_nxt, ocol_r, ocol_nxt;
  logic [RW-1:0] row_r, row_nxt, orow_r, orow_nxt;

  // accept stage decode
  logic          in_acc, is_drain, at_origin, emit, zero, last;
  logic [CW-1:0] e_col;
  logic [RW-1:0] e_row;
  csh_pkg::pix_t px, last_px_r;

  // second stage: line store data arrives
  logic          b_valid_r, b_pixel_r, b_emit_r, b_zero_r, b_last_r, b_move;
  logic [CW-1:0] b_addr_r;
  csh_pkg::pix_t b_down_r;
  csh_pkg::pix_t mid_rd, up_rd;
  csh_pkg::pix_t win_r [3];   // left, center, up of the pixel in the second stage
  csh_pkg::pix_t lane_y;
  csh_pkg::out_t merged, out_r;
  logic          out_valid_r;

  csh_pkg::ram_ctl_t mid_ctl, up_ctl;

  // ---- effective frame size ----
  always_comb begin
    if (width_r < DW'(csh_pkg::MIN_DIM)) begin
      w_eff = DW'(csh_pkg::MIN_DIM);
    end else if (width_r > DW'(csh_pkg::MAX_WIDTH)) begin
      w_eff = DW'(csh_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
    if (height_r < DW'(csh_pkg::MIN_DIM)) begin
      h_eff = DW'(csh_pkg::MIN_DIM);
    end else if (height_r > DW'(csh_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(csh_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_r;
    end
    wm1 = w_eff - DW'(1);
    hm1 = h_eff - DW'(1);
  end

  // ---- handshake ----
  // second stage moves whenever the output register is free or being taken
  assign b_move   = b_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = b_valid_r && out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  assign px = {in_data.in_red, in_data.in_green, in_data.in_blue};

  // ---- accept stage: positions, result slot, border and frame end ----
  always_comb begin
    is_drain  = (in_data.req_type == csh_pkg::REQ_DRAIN);
    at_origin = (col_r == '0) && (row_r == '0);
    emit      = 1'b0;
    e_col     = ocol_r;
    e_row     = orow_r;
    if (is_drain) begin
      // flush only between frames and only while results are pending
      emit = at_origin && !((orow_r == '0) && (ocol_r == '0));
    end else if ((col_r != '0) && (row_r != '0)) begin
      emit  = 1'b1;
      e_col = col_r - CW'(1);
      e_row = row_r - RW'(1);
    end else if ((col_r == '0) && (row_r >= RW'(2))) begin
      // first pixel of a row closes the last column of the row two above
      emit  = 1'b1;
      e_col = wm1[CW-1:0];
      e_row = row_r - RW'(2);
    end

    last = (DW'(e_row) >= hm1) && (DW'(e_col) >= wm1);
    zero = is_drain || (e_row == '0) || (DW'(e_row) >= hm1) ||
           (e_col == '0) || (DW'(e_col) >= wm1);

    // output position
    ocol_nxt = ocol_r;
    orow_nxt = orow_r;
    if (!is_drain && at_origin) begin
      ocol_nxt = '0;
      orow_nxt = '0;
    end
    if (emit) begin
      if (last) begin
        ocol_nxt = '0;
        orow_nxt = '0;
      end else if (DW'(e_col) + DW'(1) >= w_eff) begin
        ocol_nxt = '0;
        orow_nxt = e_row + RW'(1);
      end else begin
        ocol_nxt = e_col + CW'(1);
        orow_nxt = e_row;
      end
    end

    // input position, pixels only
    col_nxt = col_r;
    row_nxt = row_r;
    if (!is_drain) begin
      if (DW'(col_r) + DW'(1) >= w_eff) begin
        col_nxt = '0;
        row_nxt = (DW'(row_r) + DW'(1) >= h_eff) ? '0 : row_r + RW'(1);
      end else begin
        col_nxt = col_r + CW'(1);
      end
    end
  end

  // ---- line stores ----
  // middle holds the previous row; it is read and rewritten at the current
  // column in the accept cycle. upper gets the middle row's old value when
  // the second stage moves on, once that value comes out of the middle store.
  always_comb begin
    mid_ctl.we    = in_acc && !is_drain;
    mid_ctl.waddr = col_r;
    mid_ctl.re    = in_acc && !is_drain;
    mid_ctl.raddr = col_r;
    up_ctl.we     = b_move && b_pixel_r;
    up_ctl.waddr  = b_addr_r;
    up_ctl.re     = in_acc && !is_drain;
    up_ctl.raddr  = col_r;
  end

  csh_line_ram u_mid_ram (
    .clk     (clk),
    .ctl     (mid_ctl),
    .wdata   (px),
    .rdata_r (mid_rd)
  );

  csh_line_ram u_up_ram (
    .clk     (clk),
    .ctl     (up_ctl),
    .wdata   (mid_rd),
    .rdata_r (up_rd)
  );

  // ---- channel lanes ----
  for (genvar k = 0; k < csh_pkg::CHANNELS; k++) begin : g_lane
    csh_lane u_lane (
      .c (win_r[1][k]),
      .l (win_r[0][k]),
      .r (mid_rd[k]),
      .u (win_r[2][k]),
      .d (b_down_r[k]),
      .y (lane_y[k])
    );
  end

  // ---- merge: border and drain results are zero ----
  always_comb begin
    merged.out_blue  = b_zero_r ? '0 : lane_y[0];
    merged.out_green = b_zero_r ? '0 : lane_y[1];
    merged.out_red   = b_zero_r ? '0 : lane_y[2];
    merged.frame_end = b_last_r;
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DW'(640);
      height_r    <= DW'(480);
      col_r       <= '0;
      row_r       <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      win_r[0]    <= '0;
      win_r[1]    <= '0;
      win_r[2]    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          csh_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_data;
          csh_pkg::REG_FRAME_HEIGHT: height_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        col_r  <= col_nxt;
        row_r  <= row_nxt;
        ocol_r <= ocol_nxt;
        orow_r <= orow_nxt;
      end
      if (in_acc) begin
        b_valid_r <= !is_drain || emit;
      end else if (b_move) begin
        b_valid_r <= 1'b0;
      end
      if (b_move && b_pixel_r) begin
        win_r[0] <= win_r[1];
        win_r[1] <= mid_rd;
        win_r[2] <= up_rd;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= b_valid_r && b_emit_r;
      end
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_pixel_r <= !is_drain;
      b_emit_r  <= emit;
      b_zero_r  <= zero;
      b_last_r  <= last;
      b_addr_r  <= col_r;
      if (!is_drain) begin
        // pixel below the center is the one accepted just before this one
        b_down_r  <= (col_r != '0) ? last_px_r : '0;
        last_px_r <= px;
      end
    end
    if (b_move) begin
      out_r <= merged;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### rtl/csh_checker.sv
// Port-level checks for the cross-kernel sharpen block, bound to the top level.
`default_nettype none
module csh_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire csh_pkg::out_t                 out_data
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // input backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // a new result needs an accepted transaction that filled the second stage ahead of it
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without a matching transaction");

  // bottom-right pixel lies on the border
  a_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_end |->
      (out_data.out_blue == '0) && (out_data.out_green == '0) &&
      (out_data.out_red == '0))
    else $error("frame end result not zero");

endmodule

bind cross_kernel_sharpen csh_checker u_csh_checker (.*);
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for the cross-kernel sharpen filter: directed frames, then random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Run shape. The random part counts pixels only; drain ticks add about a
  // fifth on top.
  localparam int unsigned RANDOM_PIXELS = 1500;
  // Cycles to let pass after the last result before a register write or the end.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned MISMATCH_PRINTS = 10;

  // Idle profile of each phase, picked by phase number: none, sender only,
  // receiver only, both.
  localparam int unsigned SENDER_GAP_PCT [4] = '{0, 47, 0, 27};
  localparam int unsigned RECEIVER_STALL_PCT [4] = '{0, 0, 47, 27};

  // One directed row: the transaction, and, when typed is set, the result
  // that it must produce. Rows without a typed result go to the predictor.
  typedef struct {
    csh_pkg::in_t  txn;
    bit            typed;
    csh_pkg::out_t px;
  } stim_row_t;

  // Side note travelling with each driven transaction to the checker.
  typedef struct {
    bit            typed;
    csh_pkg::out_t px;
  } row_note_t;

  logic clk;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [csh_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [csh_pkg::DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  csh_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  csh_pkg::out_t out_data;

  int unsigned sender_gap_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned random_pixels = 0;

  // Sharpened pixels still owed by the block, oldest first.
  csh_pkg::out_t sharpened_fifo[$];
  row_note_t row_notes[$];

  // Shadow state of the filter: registers, two line stores, 3-pixel window
  // and the input / output raster positions.
  logic [csh_pkg::DIM_W-1:0] width_reg = 13'd640;
  logic [csh_pkg::DIM_W-1:0] height_reg = 13'd480;
  csh_pkg::pix_t row_upper [csh_pkg::MAX_WIDTH];
  csh_pkg::pix_t row_middle [csh_pkg::MAX_WIDTH];
  csh_pkg::pix_t win_left = '0;
  csh_pkg::pix_t win_center = '0;
  csh_pkg::pix_t win_up = '0;
  int unsigned col_in = 0;
  int unsigned row_in = 0;
  int unsigned col_out = 0;
  int unsigned row_out = 0;

  stim_row_t dir_rows [24];
  row_note_t note;
  csh_pkg::out_t predicted;
  csh_pkg::out_t want;

  cross_kernel_sharpen u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Line stores start at zero; entries never written only ever feed border
  // results, so their value never shows at the output.
  initial begin
    for (int i = 0; i < csh_pkg::MAX_WIDTH; i++) begin
      row_upper[i] = '0;
      row_middle[i] = '0;
    end
  end

  // Register values outside 3..limit saturate.
  function automatic int unsigned clamp_dim(input logic [csh_pkg::DIM_W-1:0] v,
                                            input int unsigned hi);
    if (v < csh_pkg::MIN_DIM) return csh_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // 5*center - left - right - up - down per channel, clamped to 0..255.
  function automatic csh_pkg::pix_t cross_sharpen(input csh_pkg::pix_t c,
                                                  input csh_pkg::pix_t l,
                                                  input csh_pkg::pix_t r,
                                                  input csh_pkg::pix_t u,
                                                  input csh_pkg::pix_t d);
    csh_pkg::pix_t res;
    int   v;
    res = '0;
    for (int k = 0; k < csh_pkg::CHANNELS; k++) begin
      v = 5 * int'(c[k]) - int'(l[k]) - int'(r[k]) - int'(u[k]) - int'(d[k]);
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      res[k] = v[7:0];
    end
    return res;
  endfunction

  // Advances the shadow filter by one accepted transaction. Returns 1 when the
  // transaction yields a sharpened pixel, which is placed in result.
  function automatic bit sharpen_step(input csh_pkg::in_t t, output csh_pkg::out_t result);
    int unsigned w, h, ic, ir, orow, ocol;
    csh_pkg::pix_t px, right, upnext, down, res;
    bit have, border, last;
    w = clamp_dim(width_reg, csh_pkg::MAX_WIDTH);
    h = clamp_dim(height_reg, csh_pkg::MAX_HEIGHT);
    ic = col_in;
    ir = row_in;
    result = '0;
    res = '0;
    have = 1'b0;
    orow = 0;
    ocol = 0;
    if (t.req_type == csh_pkg::REQ_DRAIN) begin
      // Drain only flushes between frames, and only while something is pending.
      if (ir != 0 || ic != 0 || (row_out == 0 && col_out == 0)) return 1'b0;
      have = 1'b1;
      orow = row_out;
      ocol = col_out;
    end else begin
      px = {t.in_red, t.in_green, t.in_blue};
      right = row_middle[ic];
      upnext = row_upper[ic];
      down = (ic >= 1) ? row_middle[ic-1] : '0;
      // New frame drops whatever the previous frame left undrained.
      if (ir == 0 && ic == 0) begin
        row_out = 0;
        col_out = 0;
      end
      if (ic >= 1 && ir >= 1) begin
        have = 1'b1;
        orow = ir - 1;
        ocol = ic - 1;
      end else if (ic == 0 && ir >= 2) begin
        have = 1'b1;
        orow = ir - 2;
        ocol = w - 1;
      end
      if (have) begin
        border = (orow == 0) || (orow >= h - 1) || (ocol == 0) || (ocol >= w - 1);
        if (!border) res = cross_sharpen(win_center, win_left, right, win_up, down);
      end
      win_left = win_center;
      win_center = right;
      win_up = upnext;
      row_upper[ic] = right;
      row_middle[ic] = px;
      if (ic + 1 >= w) begin
        col_in = 0;
        row_in = (ir + 1 >= h) ? 0 : ir + 1;
      end else begin
        col_in = ic + 1;
      end
    end
    if (have) begin
      last = (orow >= h - 1) && (ocol >= w - 1);
      result.out_blue = res[0];
      result.out_green = res[1];
      result.out_red = res[2];
      result.frame_end = last;
      if (last) begin
        row_out = 0;
        col_out = 0;
      end else if (ocol + 1 >= w) begin
        col_out = 0;
        row_out = orow + 1;
      end else begin
        col_out = ocol + 1;
        row_out = orow;
      end
    end
    return have;
  endfunction

  task automatic report_mismatch(input csh_pkg::out_t exp_px, input csh_pkg::out_t got_px,
                                 input bit unexpected);
    mismatches++;
    if (mismatches <= MISMATCH_PRINTS) begin
      if (unexpected)
        $display("[%0t] unexpected result b=%0d g=%0d r=%0d end=%0b", $realtime,
                 got_px.out_blue, got_px.out_green, got_px.out_red, got_px.frame_end);
      else
        $display("[%0t] mismatch: expected b=%0d g=%0d r=%0d end=%0b, got b=%0d g=%0d r=%0d end=%0b",
                 $realtime, exp_px.out_blue, exp_px.out_green, exp_px.out_red,
                 exp_px.frame_end, got_px.out_blue, got_px.out_green, got_px.out_red,
                 got_px.frame_end);
    end
  endtask

  // Input side feeds the predictor, output side is checked against the oldest
  // owed pixel. Everything sampled here is the value from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        note = row_notes.pop_front();
        if (sharpen_step(in_data, predicted))
          sharpened_fifo.push_back(note.typed ? note.px : predicted);
      end
      if (out_valid && !out_stall) begin
        if (sharpened_fifo.size() == 0) begin
          report_mismatch('0, out_data, 1'b1);
        end else begin
          want = sharpened_fifo.pop_front();
          if (want.out_blue !== out_data.out_blue || want.out_green !== out_data.out_green ||
              want.out_red !== out_data.out_red || want.frame_end !== out_data.frame_end)
            report_mismatch(want, out_data, 1'b0);
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Drives one transaction: optional idle gap, then hold it until accepted.
  task automatic push_txn(input csh_pkg::in_t t, input bit typed, input csh_pkg::out_t px);
    row_note_t n;
    n.typed = typed;
    n.px = px;
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    row_notes.push_back(n);
    in_valid <= 1'b1;
    in_data <= t;
    do @(posedge clk); while (in_stall);
  endtask

  // Waits until the block owes nothing and has settled, then rewrites both
  // frame registers, first letting the last accepted transaction reach the
  // predictor.
  task automatic resize_frame(input logic [csh_pkg::DIM_W-1:0] w,
                              input logic [csh_pkg::DIM_W-1:0] h);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sharpened_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= csh_pkg::REG_FRAME_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    width_reg = w;
    cfg_index <= csh_pkg::REG_FRAME_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we <= 1'b0;
  endtask

  // Drain tick; its channel bits are don't-care, so they are randomized.
  function automatic csh_pkg::in_t drain_txn();
    csh_pkg::in_t t;
    t = csh_pkg::in_t'($urandom);
    t.req_type = csh_pkg::REQ_DRAIN;
    return t;
  endfunction

  // Pixel styles: 0 uniform noise, 1 smooth (mid-range results),
  // 2 saturated channels (hits both clamps).
  function automatic csh_pkg::in_t make_pixel(input int unsigned style);
    csh_pkg::in_t t;
    t = csh_pkg::in_t'($urandom);
    t.req_type = csh_pkg::REQ_PIXEL;
    if (style == 1) begin
      t.in_blue = 8'($urandom_range(100, 140));
      t.in_green = 8'($urandom_range(100, 140));
      t.in_red = 8'($urandom_range(100, 140));
    end else if (style == 2) begin
      t.in_blue = $urandom_range(1) ? 8'hFF : 8'h00;
      t.in_green = $urandom_range(1) ? 8'hFF : 8'h00;
      t.in_red = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return t;
  endfunction

  // One frame of w x h pixels with stray drain ticks, then a tail: mostly a
  // full drain, sometimes extra idle drains, a partial drain or none at all.
  task automatic stream_frame(input int unsigned w, input int unsigned h);
    int unsigned style, tail, n_drain;
    style = $urandom_range(0, 2);
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        if ($urandom_range(39) == 0) push_txn(drain_txn(), 1'b0, '0);
        push_txn(make_pixel(style), 1'b0, '0);
      end
    end
    tail = $urandom_range(9);
    if (tail <= 6) n_drain = w + 1;
    else if (tail == 7) n_drain = w + 1 + $urandom_range(1, 3);
    else if (tail == 8) n_drain = $urandom_range(1, w);
    else n_drain = 0;
    repeat (n_drain) push_txn(drain_txn(), 1'b0, '0);
  endtask

  function automatic stim_row_t stim_row(input csh_pkg::req_t q, input logic [7:0] b,
                                         input logic [7:0] g, input logic [7:0] r,
                                         input bit typed,
                                         input logic [7:0] eb, input logic [7:0] eg,
                                         input logic [7:0] er, input logic fe);
    stim_row_t s;
    s.txn.req_type = q;
    s.txn.in_blue = b;
    s.txn.in_green = g;
    s.txn.in_red = r;
    s.typed = typed;
    s.px.out_blue = eb;
    s.px.out_green = eg;
    s.px.out_red = er;
    s.px.frame_end = fe;
    return s;
  endfunction

  initial begin
    logic [csh_pkg::DIM_W-1:0] wv, hv;
    int unsigned w_eff, h_eff, n_frames, phase;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part on the smallest frame, 3x3: only the center pixel is
    // interior. Frame one: blue clamps high (255*5), green clamps low,
    // red lands mid-range: 5*60 - 10 - 20 - 30 - 40 = 200. Includes a drain
    // inside the frame, a full drain and a drain with nothing pending.
    // Frame two is left undrained, so the next frame must drop its tail.
    dir_rows = '{
      stim_row(csh_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h55, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h1E, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'hAA, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h0A, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h3C, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h14, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h80, 8'h7F, 8'h01, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h28, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFE, 8'h01, 8'hFF, 1'b1, 8'hFF, 8'h00, 8'hC8, 1'b0),
      stim_row(csh_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1),
      stim_row(csh_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h3C, 8'hC3, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h5A, 8'hA5, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h00, 8'hFF, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h01, 8'hFE, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h7F, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0),
      stim_row(csh_pkg::REQ_PIXEL, 8'h99, 8'h66, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0)
    };

    resize_frame(13'd3, 13'd3);
    foreach (dir_rows[i]) push_txn(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].px);

    // Random phases: each rewrites the frame size, sometimes with values
    // below the minimum that must saturate, and streams a few frames under
    // one idle profile.
    phase = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      sender_gap_pct = SENDER_GAP_PCT[phase % 4];
      receiver_stall_pct = RECEIVER_STALL_PCT[phase % 4];
      if ($urandom_range(7) == 0) begin
        wv = 13'($urandom_range(13, 64));
        hv = 13'($urandom_range(3, 4));
      end else begin
        wv = ($urandom_range(5) == 0) ? 13'($urandom_range(0, 2)) : 13'($urandom_range(3, 12));
        hv = ($urandom_range(5) == 0) ? 13'($urandom_range(0, 2)) : 13'($urandom_range(3, 8));
      end
      resize_frame(wv, hv);
      w_eff = clamp_dim(wv, csh_pkg::MAX_WIDTH);
      h_eff = clamp_dim(hv, csh_pkg::MAX_HEIGHT);
      n_frames = $urandom_range(1, 3);
      repeat (n_frames) begin
        stream_frame(w_eff, h_eff);
        random_pixels += w_eff * h_eff;
      end
      phase++;
    end

    // Let every owed pixel come out, then a short settle window to catch
    // anything extra.
    in_valid <= 1'b0;
    @(posedge clk);
    while (sharpened_fifo.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && sharpened_fifo.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/csh_pkg.sv
rtl/csh_line_ram.sv
rtl/csh_lane.sv
rtl/cross_kernel_sharpen.sv
rtl/csh_checker.sv
bench/testbench.sv
